// ===== design/hed_pkg.sv =====
// Shared types, character constants and lookup functions of the HTML reference decoder.
package hed_pkg;

    localparam int NAME_NUM = 5;

    // Most output bytes kept for one input transaction.
    localparam int RESULT_CAP = 64;

    // Character codes used by the sequencer and the scanner.
    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_LOW_X = 8'h78;
    localparam logic [7:0] CHAR_UP_X  = 8'h58;

    // Largest code point kept by the numeric accumulator.
    localparam logic [20:0] CP_SAT = 21'h1FFFFF;

    // Named references, packed from the first character in the top byte.
    localparam logic [31:0] NAME_STR [NAME_NUM] = '{
        {"amp", 8'h00}, {"lt", 16'h0000}, {"gt", 16'h0000}, "quot", "apos"
    };
    localparam logic [2:0] NAME_LEN [NAME_NUM] = '{3'd3, 3'd2, 3'd2, 3'd4, 3'd4};
    localparam logic [7:0] NAME_CP  [NAME_NUM] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27};

    // Outcome of a scan over the buffered reference body.
    typedef struct packed {
        logic        hit;
        logic [20:0] cp;
    } scan_t;

    // Character at position k of named reference i.
    function automatic logic [7:0] name_char(input int i, input logic [1:0] k);
        logic [31:0] s;
        s = NAME_STR[i];
        return s[31 - 8 * k -: 8];
    endfunction

    // Number of UTF-8 bytes minus one for a code point.
    function automatic logic [1:0] utf8_count(input logic [20:0] cp);
        logic [1:0] n;
        if (cp < 21'h80) begin
            n = 2'd0;
        end else if (cp < 21'h800) begin
            n = 2'd1;
        end else if (cp < 21'h10000) begin
            n = 2'd2;
        end else begin
            n = 2'd3;
        end
        return n;
    endfunction

    // Byte idx of the UTF-8 encoding of cp, which has cnt+1 bytes.
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] cnt,
                                             input logic [1:0] idx);
        logic [1:0] sh;
        logic [5:0] chunk;
        logic [7:0] lead;
        logic [7:0] r;
        sh = cnt - idx;
        case (sh)
            2'd0:    chunk = cp[5:0];
            2'd1:    chunk = cp[11:6];
            2'd2:    chunk = cp[17:12];
            default: chunk = {3'b000, cp[20:18]};
        endcase
        case (cnt)
            2'd1:    lead = 8'hC0;
            2'd2:    lead = 8'hE0;
            default: lead = 8'hF0;
        endcase
        if (cnt == 2'd0) begin
            r = cp[7:0];
        end else if (idx == 2'd0) begin
            r = lead | {2'b00, chunk};
        end else begin
            r = 8'h80 | {2'b00, chunk};
        end
        return r;
    endfunction

endpackage

// ===== design/hed_scan.sv =====
// Incremental scanner that matches names and accumulates numeric references byte by byte.
module hed_scan #(
    parameter int IDX_W = 7
) (
    input  logic              aclk,
    input  logic              clr,
    input  logic              step,
    input  logic [7:0]        b,
    input  logic [IDX_W-1:0]  k,
    input  logic [IDX_W-1:0]  len,
    output hed_pkg::scan_t    res
);
    import hed_pkg::*;

    logic [NAME_NUM-1:0] alive_reg;
    logic                num_reg;
    logic                hex_reg;
    logic                stop_reg;
    logic [20:0]         acc_reg;

    logic                is_dec;
    logic                is_hl;
    logic                is_hu;
    logic                dig_ok;
    logic [3:0]          dig_val;
    logic [25:0]         acc_wide;
    logic [20:0]         acc_sat;

    // Digit decode and one multiply-accumulate step by shift and add.
    always_comb begin
        is_dec  = (b >= 8'h30) && (b <= 8'h39);
        is_hl   = hex_reg && (b >= 8'h61) && (b <= 8'h66);
        is_hu   = hex_reg && (b >= 8'h41) && (b <= 8'h46);
        dig_ok  = is_dec || is_hl || is_hu;
        if (is_dec) begin
            dig_val = 4'(b - 8'h30);
        end else if (is_hl) begin
            dig_val = 4'(b - 8'h57);
        end else begin
            dig_val = 4'(b - 8'h37);
        end
        if (hex_reg) begin
            acc_wide = {1'b0, acc_reg, 4'b0000} + {22'd0, dig_val};
        end else begin
            acc_wide = {2'b00, acc_reg, 3'b000} + {4'b0000, acc_reg, 1'b0}
                     + {22'd0, dig_val};
        end
        acc_sat = (acc_wide > {5'd0, CP_SAT}) ? CP_SAT : acc_wide[20:0];
    end

    // Scan state advances by one buffered byte at a time.
    always_ff @(posedge aclk) begin
        if (clr) begin
            alive_reg <= '1;
            num_reg   <= 1'b0;
            hex_reg   <= 1'b0;
            stop_reg  <= 1'b0;
            acc_reg   <= '0;
        end else if (step) begin
            for (int i = 0; i < NAME_NUM; i++) begin
                alive_reg[i] <= alive_reg[i] && (k < IDX_W'(NAME_LEN[i]))
                              && (b == name_char(i, k[1:0]));
            end
            if (k == '0) begin
                num_reg <= (b == CHAR_HASH);
            end else if ((k == IDX_W'(1)) && ((b == CHAR_LOW_X) || (b == CHAR_UP_X))) begin
                hex_reg <= 1'b1;
            end else if (!stop_reg) begin
                if (dig_ok) begin
                    acc_reg <= acc_sat;
                end else begin
                    stop_reg <= 1'b1;
                end
            end
        end
    end

    // Decision for a body of length len, names taking precedence.
    always_comb begin
        res.hit = num_reg && (len != '0);
        res.cp  = acc_reg;
        for (int i = 0; i < NAME_NUM; i++) begin
            if (alive_reg[i] && (len == IDX_W'(NAME_LEN[i]))) begin
                res.hit = 1'b1;
                res.cp  = {13'd0, NAME_CP[i]};
            end
        end
    end

endmodule

// ===== design/html_entity_to_utf8_decoder.sv =====
// Top level: byte stream decoder for HTML character references with UTF-8 output.
// A literal byte goes through S_IDLE and S_FETCH; s_tready is high only in S_IDLE.
// A replayed byte after a failed reference goes through S_FETCH and S_TAKE via the
// registered buffer read. A decoded reference emits its UTF-8 bytes from S_UTF. One output
// byte is held back until the transaction ends so that the final byte can carry tlast.
// Synchronous active-low reset empties the buffer and closes any pending reference.
module html_entity_to_utf8_decoder #(
    parameter int WINDOW_BYTES = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast    // out_last
);
    import hed_pkg::*;

    localparam int DEPTH = 2 * WINDOW_BYTES;
    localparam int PW    = $clog2(DEPTH);
    localparam int FW    = $clog2(WINDOW_BYTES + 1);

    typedef enum logic [1:0] {S_IDLE, S_FETCH, S_TAKE, S_UTF} state_t;

    state_t       state_reg, state_next;
    logic [7:0]   mem [DEPTH];
    logic [7:0]   rd_data_reg;
    logic [PW-1:0] tail_reg, tail_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [PW-1:0] ws_reg, ws_next;
    logic          open_reg, open_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          last_reg, last_next;
    logic          h_valid_reg;
    logic [7:0]    h_byte_reg;
    logic          m_valid_reg;
    logic [7:0]    m_data_reg;
    logic          m_last_reg;
    logic [20:0]   cp_reg, cp_next;
    logic [1:0]    u_cnt_reg, u_cnt_next;
    logic [1:0]    u_idx_reg, u_idx_next;
    logic [6:0]    res_cnt_reg;

    logic          m_free;
    logic          can_emit;
    logic          emit_go;
    logic          emit_ok;
    logic [7:0]    emit_byte;
    logic          flush_go;
    logic          flush_last;
    logic          mem_we;
    logic          take_go;
    logic [7:0]    take_byte;
    logic          scan_clr;
    logic          scan_step;
    scan_t         scan_res;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    hed_scan #(.IDX_W(FW)) u_scan (
        .aclk (aclk),
        .clr  (scan_clr),
        .step (scan_step),
        .b    (take_byte),
        .k    (fill_reg),
        .len  (fill_reg),
        .res  (scan_res)
    );

    // Replay buffer: written on input transactions, read at the replay pointer.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[tail_reg] <= s_tdata;
        end
        rd_data_reg <= mem[rp_reg];
    end

    assign m_free   = !m_valid_reg || m_tready;
    assign can_emit = !h_valid_reg || m_free;
    assign s_tready = (state_reg == S_IDLE) && can_emit;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // Output bytes beyond the cap of one input transaction are dropped.
    assign emit_ok = emit_go
                   && ((state_reg == S_IDLE) || (res_cnt_reg != 7'(RESULT_CAP)));

    // Sequencer: one byte through the reference logic per step.
    always_comb begin
        state_next = state_reg;
        tail_next  = tail_reg;
        rp_next    = rp_reg;
        ws_next    = ws_reg;
        open_next  = open_reg;
        fill_next  = fill_reg;
        last_next  = last_reg;
        cp_next    = cp_reg;
        u_cnt_next = u_cnt_reg;
        u_idx_next = u_idx_reg;
        emit_go    = 1'b0;
        emit_byte  = '0;
        flush_go   = 1'b0;
        flush_last = 1'b0;
        mem_we     = 1'b0;
        take_go    = 1'b0;
        scan_clr   = 1'b0;
        scan_step  = 1'b0;
        take_byte  = (state_reg == S_IDLE) ? s_tdata : rd_data_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && can_emit) begin
                    mem_we     = 1'b1;
                    tail_next  = ptr_inc(tail_reg);
                    rp_next    = ptr_inc(tail_reg);
                    last_next  = s_tlast;
                    take_go    = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                if (rp_reg != tail_reg) begin
                    state_next = S_TAKE;
                end else if (last_reg && open_reg) begin
                    // End of text with a reference still open: it fails.
                    if (can_emit) begin
                        emit_go   = 1'b1;
                        emit_byte = CHAR_AMP;
                        rp_next   = ws_reg;
                        open_next = 1'b0;
                    end
                end else if (h_valid_reg) begin
                    if (m_free) begin
                        flush_go   = 1'b1;
                        flush_last = last_reg;
                        state_next = S_IDLE;
                    end
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_TAKE: begin
                if (can_emit) begin
                    take_go    = 1'b1;
                    rp_next    = ptr_inc(rp_reg);
                    state_next = S_FETCH;
                end
            end
            S_UTF: begin
                if (can_emit) begin
                    emit_go   = 1'b1;
                    emit_byte = utf8_byte(cp_reg, u_cnt_reg, u_idx_reg);
                    if (u_idx_reg == u_cnt_reg) begin
                        state_next = S_FETCH;
                    end else begin
                        u_idx_next = u_idx_reg + 2'd1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase

        // Reference handling for the byte taken in this cycle.
        if (take_go) begin
            if (!open_reg) begin
                if (take_byte == CHAR_AMP) begin
                    open_next = 1'b1;
                    fill_next = '0;
                    ws_next   = rp_next;
                    scan_clr  = 1'b1;
                end else begin
                    emit_go   = 1'b1;
                    emit_byte = take_byte;
                end
            end else if (take_byte == CHAR_SEMI) begin
                if (scan_res.hit) begin
                    cp_next    = scan_res.cp;
                    u_cnt_next = utf8_count(scan_res.cp);
                    u_idx_next = 2'd0;
                    open_next  = 1'b0;
                    state_next = S_UTF;
                end else begin
                    emit_go   = 1'b1;
                    emit_byte = CHAR_AMP;
                    rp_next   = ws_reg;
                    open_next = 1'b0;
                end
            end else begin
                scan_step = 1'b1;
                fill_next = fill_reg + FW'(1);
                if (fill_next >= FW'(WINDOW_BYTES - 1)) begin
                    // Window full without a semicolon.
                    emit_go   = 1'b1;
                    emit_byte = CHAR_AMP;
                    rp_next   = ws_reg;
                    open_next = 1'b0;
                end
            end
        end
    end

    // State, pointers and the held and output byte registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            tail_reg    <= '0;
            rp_reg      <= '0;
            ws_reg      <= '0;
            open_reg    <= 1'b0;
            fill_reg    <= '0;
            last_reg    <= 1'b0;
            h_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
            res_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            tail_reg  <= tail_next;
            rp_reg    <= rp_next;
            ws_reg    <= ws_next;
            open_reg  <= open_next;
            fill_reg  <= fill_next;
            last_reg  <= last_next;
            // Output bytes counted per input transaction.
            if (state_reg == S_IDLE) begin
                res_cnt_reg <= {6'd0, emit_go};
            end else if (emit_ok) begin
                res_cnt_reg <= res_cnt_reg + 7'd1;
            end
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (emit_ok) begin
                if (h_valid_reg) begin
                    m_valid_reg <= 1'b1;
                    m_data_reg  <= h_byte_reg;
                    m_last_reg  <= 1'b0;
                end
                h_valid_reg <= 1'b1;
                h_byte_reg  <= emit_byte;
            end else if (flush_go) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= h_byte_reg;
                m_last_reg  <= flush_last;
                h_valid_reg <= 1'b0;
            end
        end
        cp_reg    <= cp_next;
        u_cnt_reg <= u_cnt_next;
        u_idx_reg <= u_idx_next;
    end

endmodule
